@@ src/tty_line_discipline_assert.svh @@
// assertion macros shared by the tty line discipline rtl
`ifndef TTY_LINE_DISCIPLINE_ASSERT_SVH
`define TTY_LINE_DISCIPLINE_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define TLD_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tld assertion failed");

// consequent must hold in the same cycle as the antecedent
`define TLD_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tld assertion failed");

// consequent must hold in the cycle after the antecedent
`define TLD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tld assertion failed");

`endif

@@ src/tld_pkg.sv @@
// types and constants for the tty line discipline
`default_nettype none

package tld_pkg;

    localparam int BUF_DEPTH_DEFAULT = 64;
    localparam int DATA_W            = 8;
    localparam int LEN_W             = 6;
    localparam int KIND_W            = 2;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;

    // special key codes
    localparam logic [DATA_W-1:0] KEY_NUL    = 8'd0;
    localparam logic [DATA_W-1:0] KEY_CTRL_C = 8'd3;
    localparam logic [DATA_W-1:0] KEY_CTRL_D = 8'd4;
    localparam logic [DATA_W-1:0] KEY_BS     = 8'd8;
    localparam logic [DATA_W-1:0] KEY_NL     = 8'd10;

    // operation codes
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // register select, taken from paddr bit 2
    localparam logic REG_LINE_MODE   = 1'b0;
    localparam logic REG_ECHO_ENABLE = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_KEY   = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_END   = 2'd2,
        KIND_BLOCK = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_DATA,
        ST_END,
        ST_BLOCK
    } state_t;

endpackage

`default_nettype wire

@@ src/tty_line_discipline.sv @@
// tty line discipline: key intake, line editing and reader drain over a ring buffer
//
// input channel (in_valid/in_ready) carries one word per item: operation picks a key
// byte or a read request of up to read_length bytes
// output channel (out_valid/out_ready) carries result words; last marks the final
// word of an item
// a key or would-block item loads its word in st_key or st_block when slot_free
// a read item fetches the head byte on acceptance, then loads one data word per
// cycle from st_data while the output register is free, and the end word from
// st_end; a ctrl-d that stops it yields no data word; the ring ram read
// port sets the pace, fetching the next byte while the current one is handed over
// an empty buffer gives a single would-block word; a ctrl-d at the head stops the
// drain and is consumed only when nothing was delivered before it
// one item is worked on at a time; in_ready is high only between items, but a
// finished word may still wait in the output register while the next item is taken
// a stalled receiver simply holds the block in its current step; nothing is lost
// reset empties the buffer and sets line mode and echo on; the ring ram itself is
// not cleared since only written bytes are ever read
// configuration goes through the apb port: line_mode at 0x0, echo_enable at 0x4
`default_nettype none

module tty_line_discipline #(
    parameter int BUF_DEPTH = tld_pkg::BUF_DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // apb configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tld_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tld_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [tld_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    // input words
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           operation,
    input  wire logic [tld_pkg::DATA_W-1:0]     key_byte,
    input  wire logic [tld_pkg::LEN_W-1:0]      read_length,
    // result words
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [tld_pkg::KIND_W-1:0]     result_kind,
    output logic      [tld_pkg::DATA_W-1:0]     data_byte,
    output logic                                echo_valid,
    output logic      [tld_pkg::DATA_W-1:0]     echo_byte,
    output logic                                wake_reader,
    output logic      [tld_pkg::LEN_W-1:0]      bytes_read,
    output logic                                last
);

    import tld_pkg::*;

    `include "tty_line_discipline_assert.svh"

    localparam int IDX_W = $clog2(BUF_DEPTH);
    localparam logic [IDX_W-1:0] FILL_MAX = IDX_W'(BUF_DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(BUF_DEPTH);

    // control state
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  read_index_reg, read_index_next;
    logic [IDX_W-1:0]  fill_count_reg, fill_count_next;
    logic              line_mode_reg, line_mode_next;
    logic              echo_enable_reg, echo_enable_next;
    logic              out_valid_reg, out_valid_next;

    // per item working values
    logic [LEN_W-1:0]  want_reg, want_next;
    logic [LEN_W-1:0]  got_reg, got_next;
    logic              key_ev_reg, key_ev_next;
    logic [DATA_W-1:0] key_eb_reg, key_eb_next;
    logic              key_wake_reg, key_wake_next;

    // output word register
    kind_t             kind_reg, kind_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              ev_reg, ev_next;
    logic [DATA_W-1:0] eb_reg, eb_next;
    logic              wake_reg, wake_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic              last_reg, last_next;

    // ring ram ports
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    // helpers
    logic              cfg_write;
    logic              slot_free;
    logic [IDX_W:0]    tail_sum;
    logic [IDX_W-1:0]  tail_pos;
    logic [IDX_W-1:0]  head_inc;
    logic [LEN_W-1:0]  got_inc;
    logic              is_discard;
    logic              is_erase;
    logic              store_ok;
    logic              erase_ok;

    tld_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BUF_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (key_byte),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // apb side: always ready, registers selected by address bit 2
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = {{(APB_DATA_W-1){1'b0}},
                        (paddr[2] == REG_ECHO_ENABLE) ? echo_enable_reg : line_mode_reg};

    // tail position for a new key, head position after one byte is taken
    assign tail_sum  = {1'b0, read_index_reg} + {1'b0, fill_count_reg};
    assign tail_pos  = (tail_sum >= DEPTH_EXT) ? IDX_W'(tail_sum - DEPTH_EXT)
                                               : tail_sum[IDX_W-1:0];
    assign head_inc  = (read_index_reg == FILL_MAX) ? '0 : read_index_reg + 1'b1;
    assign got_inc   = got_reg + 1'b1;
    assign mem_waddr = tail_pos;

    // key classification
    assign is_discard = (key_byte == KEY_CTRL_C) || (key_byte == KEY_NUL);
    assign is_erase   = (key_byte == KEY_BS) && line_mode_reg;
    assign store_ok   = !is_discard && !is_erase && (fill_count_reg != FILL_MAX);
    assign erase_ok   = is_erase && (fill_count_reg != '0);

    // the output register may be loaded when empty or being emptied
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        read_index_next  = read_index_reg;
        fill_count_next  = fill_count_reg;
        line_mode_next   = line_mode_reg;
        echo_enable_next = echo_enable_reg;
        want_next        = want_reg;
        got_next         = got_reg;
        key_ev_next      = key_ev_reg;
        key_eb_next      = key_eb_reg;
        key_wake_next    = key_wake_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        kind_next        = kind_reg;
        data_next        = data_reg;
        ev_next          = ev_reg;
        eb_next          = eb_reg;
        wake_next        = wake_reg;
        count_next       = count_reg;
        last_next        = last_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_raddr        = read_index_reg;
        in_ready         = 1'b0;

        if (cfg_write)
        begin
            case (paddr[2])
                REG_LINE_MODE:   line_mode_next   = pwdata[0];
                REG_ECHO_ENABLE: echo_enable_next = pwdata[0];
                default:         line_mode_next   = line_mode_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (operation == OP_KEY)
                    begin
                        mem_we        = store_ok;
                        key_ev_next   = echo_enable_reg && (store_ok || erase_ok);
                        key_eb_next   = !echo_enable_reg ? KEY_NUL
                                      : store_ok ? key_byte
                                      : erase_ok ? KEY_BS : KEY_NUL;
                        key_wake_next = store_ok && ((key_byte == KEY_NL) ||
                                        (key_byte == KEY_CTRL_D) || !line_mode_reg);
                        if (store_ok)
                        begin
                            fill_count_next = fill_count_reg + 1'b1;
                        end
                        else if (erase_ok)
                        begin
                            fill_count_next = fill_count_reg - 1'b1;
                        end
                        state_next = ST_KEY;
                    end
                    else
                    begin
                        // fetch the head byte straight away
                        mem_re    = 1'b1;
                        want_next = read_length;
                        got_next  = '0;
                        if (fill_count_reg == '0)
                        begin
                            state_next = ST_BLOCK;
                        end
                        else if (read_length == '0)
                        begin
                            state_next = ST_END;
                        end
                        else
                        begin
                            state_next = ST_DATA;
                        end
                    end
                end
            end

            ST_KEY:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_KEY;
                    data_next      = '0;
                    ev_next        = key_ev_reg;
                    eb_next        = key_eb_reg;
                    wake_next      = key_wake_reg;
                    count_next     = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_DATA:
            begin
                if (mem_rdata == KEY_CTRL_D)
                begin
                    // ctrl-d ends the read, consumed only at the start
                    if (got_reg == '0)
                    begin
                        read_index_next = head_inc;
                        fill_count_next = fill_count_reg - 1'b1;
                    end
                    state_next = ST_END;
                end
                else if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = KIND_DATA;
                    data_next       = mem_rdata;
                    ev_next         = 1'b0;
                    eb_next         = '0;
                    wake_next       = 1'b0;
                    count_next      = '0;
                    last_next       = 1'b0;
                    read_index_next = head_inc;
                    fill_count_next = fill_count_reg - 1'b1;
                    got_next        = got_inc;
                    // prefetch the following byte
                    mem_re          = 1'b1;
                    mem_raddr       = head_inc;
                    if ((got_inc == want_reg) || (fill_count_reg == IDX_W'(1)))
                    begin
                        state_next = ST_END;
                    end
                end
            end

            ST_END:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_END;
                    data_next      = '0;
                    ev_next        = 1'b0;
                    eb_next        = '0;
                    wake_next      = 1'b0;
                    count_next     = got_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_BLOCK:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_BLOCK;
                    data_next      = '0;
                    ev_next        = 1'b0;
                    eb_next        = '0;
                    wake_next      = 1'b0;
                    count_next     = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            read_index_reg  <= '0;
            fill_count_reg  <= '0;
            line_mode_reg   <= 1'b1;
            echo_enable_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            read_index_reg  <= read_index_next;
            fill_count_reg  <= fill_count_next;
            line_mode_reg   <= line_mode_next;
            echo_enable_reg <= echo_enable_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        want_reg     <= want_next;
        got_reg      <= got_next;
        key_ev_reg   <= key_ev_next;
        key_eb_reg   <= key_eb_next;
        key_wake_reg <= key_wake_next;
        kind_reg     <= kind_next;
        data_reg     <= data_next;
        ev_reg       <= ev_next;
        eb_reg       <= eb_next;
        wake_reg     <= wake_next;
        count_reg    <= count_next;
        last_reg     <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign data_byte   = data_reg;
    assign echo_valid  = ev_reg;
    assign echo_byte   = eb_reg;
    assign wake_reader = wake_reg;
    assign bytes_read  = count_reg;
    assign last        = last_reg;

    // buffer never holds more than depth minus one bytes
    `TLD_ASSERT_ALWAYS(a_fill_bound, fill_count_reg <= FILL_MAX)
    // a ctrl-d is never handed to the reader as data
    `TLD_ASSERT_SAME(a_no_eof_data, out_valid_reg && (kind_reg == KIND_DATA),
                     data_reg != KEY_CTRL_D)
    // every key word closes its item
    `TLD_ASSERT_SAME(a_key_last, out_valid_reg && (kind_reg == KIND_KEY), last_reg)
    // a read on an empty buffer goes to the would-block step
    `TLD_ASSERT_NEXT(a_empty_block,
                     in_valid && in_ready && (operation == OP_READ) &&
                     (fill_count_reg == '0),
                     state_reg == ST_BLOCK)

endmodule

`default_nettype wire

@@ src/tld_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module tld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
